// ===== design/fmp_pkg.sv =====
// Shared types and constants of the escape-time fractal pixel block.
package fmp_pkg;

   // Configuration port geometry and register widths
   localparam int CSR_ADDR_W = 3;
   localparam int REG_W      = 32;
   localparam int SIZE_W     = 13;
   localparam int RAD_W      = 31;
   localparam int ITER_W     = 16;
   localparam int GRAY_W     = 8;

   // Working width of z between steps: |z| stays below the escape radius
   localparam int Z_W = 32;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_X_MIN          = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_X_MAX          = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_Y_MIN          = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_Y_MAX          = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_IMAGE_WIDTH    = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_IMAGE_HEIGHT   = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_ESCAPE_RADIUS  = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_MAX_ITERATIONS = 3'd7;

   // Full-scale gray level
   localparam logic [GRAY_W-1:0] GRAY_SCALE = 8'd255;

   typedef struct packed {
      logic signed [REG_W-1:0] x_min;
      logic signed [REG_W-1:0] x_max;
      logic signed [REG_W-1:0] y_min;
      logic signed [REG_W-1:0] y_max;
      logic [SIZE_W-1:0]       image_width;
      logic [SIZE_W-1:0]       image_height;
      logic [RAD_W-1:0]        escape_radius;
      logic [ITER_W-1:0]       max_iterations;
   } cfg_type;

   // Region -2.0 .. 1.0 by -1.0 .. 1.0, 640 x 480, radius 2.0, 256 steps
   localparam cfg_type CFG_RST = '{
      x_min:          -32'sd536870912,
      x_max:          32'sd268435456,
      y_min:          -32'sd268435456,
      y_max:          32'sd268435456,
      image_width:    13'd640,
      image_height:   13'd480,
      escape_radius:  31'd536870912,
      max_iterations: 16'd256
   };

endpackage

// ===== design/fmp_div.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
module fmp_div #(
   parameter int NUM_W = 24,
   parameter int DEN_W = 16,
   localparam int CNT_W = $clog2(NUM_W + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   trial;
   logic             fits;

   // Bring down the next dividend bit and try a subtract
   assign shifted = {rem_ff, num_ff[NUM_W-1]};
   assign trial   = shifted - {1'b0, den_ff};
   assign fits    = ~trial[DEN_W];

   // Count the steps
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Shift quotient bits in where dividend bits leave
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
         num_ff <= {num_ff[NUM_W-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quot = num_ff;

endmodule

// ===== design/fmp_queue.sv =====
// Small flip-flop queue between the point mapper and the iteration engine.
module fmp_queue #(
   parameter int W     = 126,
   parameter int DEPTH = 2,
   localparam int PTR_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   output logic         full,
   input  logic         pop,
   output logic [W-1:0] pop_data,
   output logic         empty
);

   logic [W-1:0]     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/fmp_front.sv =====
// Front end: accepts a pixel request and maps it to the point c.
module fmp_front #(
   parameter int COORD_BITS = 12,
   localparam int PROD_W = COORD_BITS + 34,
   localparam int MAG_W  = PROD_W - 1,
   localparam int C_W    = MAG_W + 2,
   localparam int QW     = 2 * COORD_BITS + 2 * C_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  fmp_pkg::cfg_type      cfg,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COORD_BITS-1:0] req_column,
   input  logic [COORD_BITS-1:0] req_row,
   output logic                  q_push,
   output logic [QW-1:0]         q_data,
   input  logic                  q_full
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_ADD,
      ST_PUSH
   } state_type;

   state_type                   state_ff;
   logic [COORD_BITS-1:0]       col_ff;
   logic [COORD_BITS-1:0]       row_ff;
   logic signed [PROD_W-1:0]    prod_x_ff;
   logic signed [PROD_W-1:0]    prod_y_ff;
   logic signed [C_W-1:0]       cx_ff;
   logic signed [C_W-1:0]       cy_ff;

   logic signed [fmp_pkg::REG_W:0] span_x;
   logic signed [fmp_pkg::REG_W:0] span_y;
   logic signed [PROD_W-1:0]    prod_x_in;
   logic signed [PROD_W-1:0]    prod_y_in;
   logic [MAG_W-1:0]            mag_x;
   logic [MAG_W-1:0]            mag_y;
   logic [MAG_W-1:0]            quot_x;
   logic [MAG_W-1:0]            quot_y;
   logic                        div_x_done;
   logic                        div_y_done;
   logic                        div_start;
   logic signed [C_W-1:0]       off_x;
   logic signed [C_W-1:0]       off_y;
   logic signed [C_W-1:0]       cx_in;
   logic signed [C_W-1:0]       cy_in;

   // Region span times pixel position
   assign span_x    = (fmp_pkg::REG_W + 1)'(cfg.x_max) - (fmp_pkg::REG_W + 1)'(cfg.x_min);
   assign span_y    = (fmp_pkg::REG_W + 1)'(cfg.y_max) - (fmp_pkg::REG_W + 1)'(cfg.y_min);
   assign prod_x_in = PROD_W'(span_x) * PROD_W'($signed({1'b0, col_ff}));
   assign prod_y_in = PROD_W'(span_y) * PROD_W'($signed({1'b0, row_ff}));

   // Divide magnitudes so the quotient truncates toward zero
   assign mag_x = prod_x_ff[PROD_W-1] ? MAG_W'(-prod_x_ff) : MAG_W'(prod_x_ff);
   assign mag_y = prod_y_ff[PROD_W-1] ? MAG_W'(-prod_y_ff) : MAG_W'(prod_y_ff);
   assign div_start = (state_ff == ST_DIV_GO);

   fmp_div #(
      .NUM_W(MAG_W),
      .DEN_W(fmp_pkg::SIZE_W)
   ) u_div_x (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num  (mag_x),
      .den  (cfg.image_width),
      .done (div_x_done),
      .quot (quot_x)
   );

   fmp_div #(
      .NUM_W(MAG_W),
      .DEN_W(fmp_pkg::SIZE_W)
   ) u_div_y (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num  (mag_y),
      .den  (cfg.image_height),
      .done (div_y_done),
      .quot (quot_y)
   );

   // Restore sign, drop the offset on a zero-sized axis, add the region edge
   always_comb begin
      if (cfg.image_width == '0) begin
         off_x = '0;
      end else if (prod_x_ff[PROD_W-1]) begin
         off_x = -$signed({2'b00, quot_x});
      end else begin
         off_x = $signed({2'b00, quot_x});
      end
      if (cfg.image_height == '0) begin
         off_y = '0;
      end else if (prod_y_ff[PROD_W-1]) begin
         off_y = -$signed({2'b00, quot_y});
      end else begin
         off_y = $signed({2'b00, quot_y});
      end
      cx_in = off_x + C_W'(cfg.x_min);
      cy_in = off_y + C_W'(cfg.y_min);
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign q_push    = (state_ff == ST_PUSH) && !q_full;
   assign q_data    = {cy_ff, cx_ff, row_ff, col_ff};

   // Sequence one request through map and hand-off
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  col_ff   <= req_column;
                  row_ff   <= req_row;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_x_ff <= prod_x_in;
               prod_y_ff <= prod_y_in;
               state_ff  <= ST_DIV_GO;
            end
            ST_DIV_GO: begin
               state_ff <= ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
               if (div_x_done && div_y_done) begin
                  state_ff <= ST_ADD;
               end
            end
            ST_ADD: begin
               cx_ff    <= cx_in;
               cy_ff    <= cy_in;
               state_ff <= ST_PUSH;
            end
            ST_PUSH: begin
               if (!q_full) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== design/fmp_back.sv =====
// Back end: iterates z = z*z + c, grades the count and holds the response.
module fmp_back #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 28,
   localparam int C_W  = COORD_BITS + 35,
   localparam int QW   = 2 * COORD_BITS + 2 * C_W,
   localparam int P_W  = 2 * fmp_pkg::Z_W,
   localparam int SH_W = 64 - FRAC_BITS,
   localparam int NZ_W = ((C_W > SH_W) ? C_W : SH_W) + 1,
   localparam int SQ_W = 2 * fmp_pkg::RAD_W,
   localparam int GN_W = fmp_pkg::ITER_W + fmp_pkg::GRAY_W
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fmp_pkg::cfg_type              cfg,
   input  logic                          q_empty,
   output logic                          q_pop,
   input  logic [QW-1:0]                 q_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [COORD_BITS-1:0]         rsp_column,
   output logic [COORD_BITS-1:0]         rsp_row,
   output logic [fmp_pkg::ITER_W-1:0]    rsp_iteration_count,
   output logic [fmp_pkg::GRAY_W-1:0]    rsp_gray_level
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_STEP,
      ST_SQR,
      ST_TEST,
      ST_GRAY_MUL,
      ST_GRAY_GO,
      ST_GRAY_WAIT,
      ST_SEND
   } state_type;

   state_type                        state_ff;
   logic [COORD_BITS-1:0]            col_ff;
   logic [COORD_BITS-1:0]            row_ff;
   logic signed [C_W-1:0]            cx_ff;
   logic signed [C_W-1:0]            cy_ff;
   logic signed [fmp_pkg::Z_W-1:0]   zr_ff;
   logic signed [fmp_pkg::Z_W-1:0]   zi_ff;
   logic signed [P_W-1:0]            p_rr_ff;
   logic signed [P_W-1:0]            p_ii_ff;
   logic signed [P_W-1:0]            p_ri_ff;
   logic [fmp_pkg::RAD_W-1:0]        ar_ff;
   logic [fmp_pkg::RAD_W-1:0]        ai_ff;
   logic                             esc_ff;
   logic [SQ_W-1:0]                  sq_r_ff;
   logic [SQ_W-1:0]                  sq_i_ff;
   logic [SQ_W-1:0]                  r2_ff;
   logic [fmp_pkg::ITER_W-1:0]       it_ff;
   logic [GN_W-1:0]                  gnum_ff;
   logic [fmp_pkg::GRAY_W-1:0]       gray_ff;
   logic                             rsp_valid_ff;
   logic [COORD_BITS-1:0]            rsp_col_ff;
   logic [COORD_BITS-1:0]            rsp_row_ff;
   logic [fmp_pkg::ITER_W-1:0]       rsp_it_ff;
   logic [fmp_pkg::GRAY_W-1:0]       rsp_gray_ff;

   logic signed [P_W-1:0]            re_diff;
   logic signed [P_W-1:0]            re_sh;
   logic signed [P_W-1:0]            im_sh;
   logic signed [NZ_W-1:0]           nzr;
   logic signed [NZ_W-1:0]           nzi;
   logic [NZ_W-1:0]                  mag_r;
   logic [NZ_W-1:0]                  mag_i;
   logic                             esc_comp;
   logic                             esc_norm;
   logic [fmp_pkg::ITER_W:0]         it_next;
   logic [fmp_pkg::ITER_W-1:0]       it_left;
   logic                             gdiv_start;
   logic                             gdiv_done;
   logic [GN_W-1:0]                  gdiv_quot;
   logic                             rsp_load;

   // New z from the registered products
   always_comb begin
      re_diff  = p_rr_ff - p_ii_ff;
      re_sh    = re_diff >>> FRAC_BITS;
      im_sh    = p_ri_ff >>> (FRAC_BITS - 1);
      nzr      = NZ_W'(re_sh) + NZ_W'(cx_ff);
      nzi      = NZ_W'(im_sh) + NZ_W'(cy_ff);
      mag_r    = nzr[NZ_W-1] ? NZ_W'(-nzr) : NZ_W'(nzr);
      mag_i    = nzi[NZ_W-1] ? NZ_W'(-nzi) : NZ_W'(nzi);
      esc_comp = (mag_r >= NZ_W'(cfg.escape_radius)) ||
                 (mag_i >= NZ_W'(cfg.escape_radius));
   end

   assign esc_norm   = ({1'b0, sq_r_ff} + {1'b0, sq_i_ff}) >= {1'b0, r2_ff};
   assign it_next    = {1'b0, it_ff} + (fmp_pkg::ITER_W + 1)'(1);
   assign it_left    = cfg.max_iterations - it_ff;
   assign gdiv_start = (state_ff == ST_GRAY_GO);
   assign q_pop      = (state_ff == ST_IDLE) && !q_empty;
   assign rsp_load   = (state_ff == ST_SEND) && (!rsp_valid_ff || rsp_ready);

   fmp_div #(
      .NUM_W(GN_W),
      .DEN_W(fmp_pkg::ITER_W)
   ) u_div_gray (
      .clock(clock),
      .reset(reset),
      .start(gdiv_start),
      .num  (gnum_ff),
      .den  (cfg.max_iterations),
      .done (gdiv_done),
      .quot (gdiv_quot)
   );

   // Square of the radius, refreshed from the register
   always_ff @(posedge clock) begin
      r2_ff <= cfg.escape_radius * cfg.escape_radius;
   end

   // Iterate one pixel, then grade and hand over the response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  col_ff <= q_data[COORD_BITS-1:0];
                  row_ff <= q_data[2*COORD_BITS-1:COORD_BITS];
                  cx_ff  <= $signed(q_data[2*COORD_BITS+C_W-1:2*COORD_BITS]);
                  cy_ff  <= $signed(q_data[QW-1:2*COORD_BITS+C_W]);
                  zr_ff  <= '0;
                  zi_ff  <= '0;
                  it_ff  <= '0;
                  state_ff <= (cfg.max_iterations == '0) ? ST_GRAY_MUL : ST_MUL;
               end
            end
            ST_MUL: begin
               p_rr_ff  <= zr_ff * zr_ff;
               p_ii_ff  <= zi_ff * zi_ff;
               p_ri_ff  <= zr_ff * zi_ff;
               state_ff <= ST_STEP;
            end
            ST_STEP: begin
               zr_ff    <= fmp_pkg::Z_W'(nzr);
               zi_ff    <= fmp_pkg::Z_W'(nzi);
               ar_ff    <= mag_r[fmp_pkg::RAD_W-1:0];
               ai_ff    <= mag_i[fmp_pkg::RAD_W-1:0];
               esc_ff   <= esc_comp;
               state_ff <= ST_SQR;
            end
            ST_SQR: begin
               sq_r_ff  <= ar_ff * ar_ff;
               sq_i_ff  <= ai_ff * ai_ff;
               state_ff <= ST_TEST;
            end
            ST_TEST: begin
               priority if (esc_ff || esc_norm) begin
                  state_ff <= ST_GRAY_MUL;
               end else if (it_next == {1'b0, cfg.max_iterations}) begin
                  it_ff    <= cfg.max_iterations;
                  state_ff <= ST_GRAY_MUL;
               end else begin
                  it_ff    <= it_next[fmp_pkg::ITER_W-1:0];
                  state_ff <= ST_MUL;
               end
            end
            ST_GRAY_MUL: begin
               if (it_ff >= cfg.max_iterations) begin
                  gray_ff  <= '0;
                  state_ff <= ST_SEND;
               end else begin
                  gnum_ff  <= GN_W'(it_left) * GN_W'(fmp_pkg::GRAY_SCALE);
                  state_ff <= ST_GRAY_GO;
               end
            end
            ST_GRAY_GO: begin
               state_ff <= ST_GRAY_WAIT;
            end
            ST_GRAY_WAIT: begin
               if (gdiv_done) begin
                  gray_ff  <= gdiv_quot[fmp_pkg::GRAY_W-1:0];
                  state_ff <= ST_SEND;
               end
            end
            ST_SEND: begin
               if (rsp_load) begin
                  rsp_col_ff   <= col_ff;
                  rsp_row_ff   <= row_ff;
                  rsp_it_ff    <= it_ff;
                  rsp_gray_ff  <= gray_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_column          = rsp_col_ff;
   assign rsp_row             = rsp_row_ff;
   assign rsp_iteration_count = rsp_it_ff;
   assign rsp_gray_level      = rsp_gray_ff;

endmodule

// ===== design/escape_time_fractal_pixel.sv =====
// Top level of the escape-time fractal pixel evaluator.
//
//   channel   direction  handshake             payload
//   req       in         req_tvalid/tready     column, row
//   rsp       out        rsp_tvalid/tready     column, row, iteration_count, gray_level
//   csr       in         csr_we                8 registers by csr_addr
//
// In the iteration engine each step of a pixel goes through product, sum, square and compare
// states on one set of multipliers, and a pixel that escapes then runs the gray divide with
// its start and wait states. A pixel that never escapes skips the divide. Point mapping
// starts after the request is taken and overlaps the previous pixel's iterations through
// a two-entry queue. Reset is synchronous and loads the default region. A stalled response
// waits in its output register while the next pixel runs.
module escape_time_fractal_pixel #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 28,
   localparam int REQ_W = ((2 * COORD_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((2 * COORD_BITS + 31) / 8) * 8,
   localparam int C_W   = COORD_BITS + 35,
   localparam int QW    = 2 * COORD_BITS + 2 * C_W
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [REQ_W-1:0]                  req_tdata,   // column, row
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [RSP_W-1:0]                  rsp_tdata,   // column, row, iteration_count, gray_level
   input  logic                              csr_we,
   input  logic [fmp_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [fmp_pkg::REG_W-1:0]         csr_wdata
);

   fmp_pkg::cfg_type                cfg_ff;
   logic                            q_push;
   logic [QW-1:0]                   q_push_data;
   logic                            q_full;
   logic                            q_pop;
   logic [QW-1:0]                   q_pop_data;
   logic                            q_empty;
   logic [COORD_BITS-1:0]           out_column;
   logic [COORD_BITS-1:0]           out_row;
   logic [fmp_pkg::ITER_W-1:0]      out_iteration_count;
   logic [fmp_pkg::GRAY_W-1:0]      out_gray_level;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= fmp_pkg::CFG_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            fmp_pkg::REG_X_MIN:          cfg_ff.x_min <= csr_wdata;
            fmp_pkg::REG_X_MAX:          cfg_ff.x_max <= csr_wdata;
            fmp_pkg::REG_Y_MIN:          cfg_ff.y_min <= csr_wdata;
            fmp_pkg::REG_Y_MAX:          cfg_ff.y_max <= csr_wdata;
            fmp_pkg::REG_IMAGE_WIDTH:    cfg_ff.image_width <= csr_wdata[fmp_pkg::SIZE_W-1:0];
            fmp_pkg::REG_IMAGE_HEIGHT:   cfg_ff.image_height <= csr_wdata[fmp_pkg::SIZE_W-1:0];
            fmp_pkg::REG_ESCAPE_RADIUS:  cfg_ff.escape_radius <= csr_wdata[fmp_pkg::RAD_W-1:0];
            fmp_pkg::REG_MAX_ITERATIONS: cfg_ff.max_iterations <= csr_wdata[fmp_pkg::ITER_W-1:0];
            default: begin
            end
         endcase
      end
   end

   fmp_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_column(req_tdata[COORD_BITS-1:0]),
      .req_row   (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .q_push    (q_push),
      .q_data    (q_push_data),
      .q_full    (q_full)
   );

   fmp_queue #(
      .W    (QW),
      .DEPTH(2)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_push_data),
      .full     (q_full),
      .pop      (q_pop),
      .pop_data (q_pop_data),
      .empty    (q_empty)
   );

   fmp_back #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .q_empty            (q_empty),
      .q_pop              (q_pop),
      .q_data             (q_pop_data),
      .rsp_valid          (rsp_tvalid),
      .rsp_ready          (rsp_tready),
      .rsp_column         (out_column),
      .rsp_row            (out_row),
      .rsp_iteration_count(out_iteration_count),
      .rsp_gray_level     (out_gray_level)
   );

   // Pack the response, zero-filled to whole bytes
   assign rsp_tdata = RSP_W'({out_gray_level, out_iteration_count, out_row, out_column});

endmodule
